FILE: design/hid_report_descriptor_scanner_unit_defines.svh
// Assertion macros for the HID report descriptor scanner.
// Included by the top level; no other dependencies.
`ifndef HID_REPORT_DESCRIPTOR_SCANNER_UNIT_DEFINES_SVH
`define HID_REPORT_DESCRIPTOR_SCANNER_UNIT_DEFINES_SVH

`ifndef SYNTH
// Plain property that must hold at every clock edge outside reset.
`define HRDS_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("hrds: check failed");
// Implication checked in the same cycle.
`define HRDS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("hrds: implication failed");
`else
`define HRDS_ASSERT(label, clk, rstn, prop)
`define HRDS_ASSERT_IMP(label, clk, rstn, ante, cons)
`endif

`endif

FILE: design/hrds_pkg.sv
// Package for the HID report descriptor scanner: item codes, limits and
// the result and push types shared by the parser, result queue and top level.
`default_nettype none

package hrds_pkg;

    // Deepest collection nesting that is tracked; the counter is 8 bits wide.
    localparam int MAX_NEST  = 255;
    localparam int NEST_CAP  = (MAX_NEST > 255) ? 255 : MAX_NEST;
    localparam logic [7:0] NEST_LIMIT = 8'(NEST_CAP);

    // Reset value of the report limit register.
    localparam logic [7:0] MAX_REPORTS_RST = 8'd4;

    // Item types.
    localparam logic [1:0] TYPE_MAIN   = 2'd0;
    localparam logic [1:0] TYPE_GLOBAL = 2'd1;
    localparam logic [1:0] TYPE_LOCAL  = 2'd2;

    // Item tags.
    localparam logic [3:0] TAG_COLLECTION     = 4'd10;
    localparam logic [3:0] TAG_COLLECTION_END = 4'd12;
    localparam logic [3:0] TAG_USAGE_PAGE     = 4'd0;
    localparam logic [3:0] TAG_REPORT_ID      = 4'd8;
    localparam logic [3:0] TAG_USAGE          = 4'd0;

    // Size code that stands for four data bytes.
    localparam logic [1:0] SIZE_FOUR = 2'd3;

    // Result kinds.
    localparam logic KIND_RECORD  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Result queue geometry.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_IDX_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Width of the packed result data word, padded to whole bytes.
    localparam int RES_DATA_W = 41;
    localparam int TDATA_W    = ((RES_DATA_W + 7) / 8) * 8;

    typedef struct packed {
        logic        kind;
        logic [7:0]  report_ident;
        logic [15:0] page_of_usage;
        logic [7:0]  usage_code;
        logic [7:0]  reports_found;
        logic        truncated;
        logic        run_end;
    } hrds_result_t;

    // Up to two results leave the parser for one byte: a record, then a summary.
    typedef struct packed {
        logic         rec_valid;
        logic         sum_valid;
        hrds_result_t rec;
        hrds_result_t sum;
    } hrds_push_t;

endpackage

`default_nettype wire

FILE: design/hrds_parser.sv
// Item parser of the HID report descriptor scanner: holds the parse state
// and turns one registered byte into up to two results. Uses hrds_pkg.
`default_nettype none

module hrds_parser (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire logic [7:0]        desc_byte,
    input  wire logic              final_byte,
    input  wire logic [7:0]        max_reports,
    output hrds_pkg::hrds_push_t   push
);
    import hrds_pkg::*;

    logic [2:0]  pend_reg,  pend_next;
    logic [1:0]  type_reg,  type_next;
    logic [3:0]  tag_reg,   tag_next;
    logic [1:0]  idx_reg,   idx_next;
    logic [15:0] accum_reg, accum_next;
    logic [7:0]  depth_reg, depth_next;
    logic [7:0]  tally_reg, tally_next;
    logic [7:0]  ident_reg, ident_next;
    logic [15:0] page_reg,  page_next;
    logic [7:0]  usage_reg, usage_next;

    logic        active;
    logic        is_hdr;
    logic [2:0]  cur_pend;
    logic [1:0]  cur_type;
    logic [3:0]  cur_tag;
    logic [1:0]  cur_idx;
    logic [15:0] cur_accum;
    logic        done;
    logic        close;
    logic        trunc;

    // Decode of the current byte as header or data byte.
    always_comb begin
        active = (tally_reg < max_reports);
        is_hdr = (pend_reg == 3'd0);
        if (is_hdr) begin
            cur_pend  = (desc_byte[1:0] == SIZE_FOUR) ? 3'd4 : {1'b0, desc_byte[1:0]};
            cur_type  = desc_byte[3:2];
            cur_tag   = desc_byte[7:4];
            cur_idx   = 2'd0;
            cur_accum = 16'd0;
        end else begin
            cur_pend = pend_reg - 3'd1;
            cur_type = type_reg;
            cur_tag  = tag_reg;
            cur_idx  = idx_reg + 2'd1;
            unique case (idx_reg)
                2'd0:    cur_accum = accum_reg | {8'd0, desc_byte};
                2'd1:    cur_accum = accum_reg | {desc_byte, 8'd0};
                default: cur_accum = accum_reg;
            endcase
        end
        done = (cur_pend == 3'd0);
    end

    // Item completion, record close and next state.
    always_comb begin
        pend_next  = pend_reg;
        type_next  = type_reg;
        tag_next   = tag_reg;
        idx_next   = idx_reg;
        accum_next = accum_reg;
        depth_next = depth_reg;
        tally_next = tally_reg;
        ident_next = ident_reg;
        page_next  = page_reg;
        usage_next = usage_reg;
        close      = 1'b0;

        if (step && active) begin
            pend_next  = cur_pend;
            type_next  = cur_type;
            tag_next   = cur_tag;
            idx_next   = cur_idx;
            accum_next = cur_accum;
            if (done) begin
                unique case (cur_type)
                    TYPE_MAIN: begin
                        if (cur_tag == TAG_COLLECTION) begin
                            if (depth_reg < NEST_LIMIT) begin
                                depth_next = depth_reg + 8'd1;
                            end
                        end else if (cur_tag == TAG_COLLECTION_END) begin
                            if (depth_reg != 8'd0) begin
                                depth_next = depth_reg - 8'd1;
                                close      = (depth_reg == 8'd1);
                            end
                        end
                    end
                    TYPE_GLOBAL: begin
                        if (cur_tag == TAG_USAGE_PAGE) begin
                            if (depth_reg == 8'd0) begin
                                page_next = cur_accum;
                            end
                        end else if (cur_tag == TAG_REPORT_ID) begin
                            ident_next = cur_accum[7:0];
                        end
                    end
                    TYPE_LOCAL: begin
                        if (cur_tag == TAG_USAGE && depth_reg == 8'd0) begin
                            usage_next = cur_accum[7:0];
                        end
                    end
                    default: begin
                        // Reserved type: data consumed, nothing changes.
                    end
                endcase
            end
            if (close) begin
                tally_next = tally_reg + 8'd1;
                ident_next = 8'd0;
                page_next  = 16'd0;
                usage_next = 8'd0;
            end
        end

        // The summary returns every parse register to its reset value.
        if (step && final_byte) begin
            pend_next  = 3'd0;
            type_next  = 2'd0;
            tag_next   = 4'd0;
            idx_next   = 2'd0;
            accum_next = 16'd0;
            depth_next = 8'd0;
            tally_next = 8'd0;
            ident_next = 8'd0;
            page_next  = 16'd0;
            usage_next = 8'd0;
        end
    end

    assign trunc = active && (cur_pend != 3'd0);

    // Results for this byte: a record on a top-level close, a summary on the last byte.
    always_comb begin
        push.rec_valid          = step && close;
        push.rec.kind           = KIND_RECORD;
        push.rec.report_ident   = ident_reg;
        push.rec.page_of_usage  = page_reg;
        push.rec.usage_code     = usage_reg;
        push.rec.reports_found  = tally_reg + 8'd1;
        push.rec.truncated      = 1'b0;
        push.rec.run_end        = !final_byte;

        push.sum_valid          = step && final_byte;
        push.sum.kind           = KIND_SUMMARY;
        push.sum.report_ident   = 8'd0;
        push.sum.page_of_usage  = 16'd0;
        push.sum.usage_code     = 8'd0;
        push.sum.reports_found  = close ? (tally_reg + 8'd1) : tally_reg;
        push.sum.truncated      = trunc;
        push.sum.run_end        = 1'b1;
    end

    // Parse state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg  <= 3'd0;
            type_reg  <= 2'd0;
            tag_reg   <= 4'd0;
            idx_reg   <= 2'd0;
            accum_reg <= 16'd0;
            depth_reg <= 8'd0;
            tally_reg <= 8'd0;
            ident_reg <= 8'd0;
            page_reg  <= 16'd0;
            usage_reg <= 8'd0;
        end else begin
            pend_reg  <= pend_next;
            type_reg  <= type_next;
            tag_reg   <= tag_next;
            idx_reg   <= idx_next;
            accum_reg <= accum_next;
            depth_reg <= depth_next;
            tally_reg <= tally_next;
            ident_reg <= ident_next;
            page_reg  <= page_next;
            usage_reg <= usage_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/hrds_result_fifo.sv
// Result queue of the HID report descriptor scanner: a small flip-flop FIFO
// that takes up to two results a cycle and hands out one. Uses hrds_pkg.
`default_nettype none

module hrds_result_fifo (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire hrds_pkg::hrds_push_t          push,
    input  wire logic                          pop,
    output hrds_pkg::hrds_result_t             head,
    output logic                               not_empty,
    output logic [hrds_pkg::FIFO_CNT_W-1:0]    count
);
    import hrds_pkg::*;

    hrds_result_t           slot_reg [FIFO_DEPTH];
    logic [FIFO_IDX_W-1:0]  wr_reg, wr_next;
    logic [FIFO_IDX_W-1:0]  rd_reg, rd_next;
    logic [FIFO_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [FIFO_CNT_W-1:0]  n_push;
    logic [FIFO_IDX_W-1:0]  wr_second;
    hrds_result_t           first_entry;

    // The record, when present, always goes ahead of the summary.
    always_comb begin
        first_entry = push.rec_valid ? push.rec : push.sum;
        wr_second   = wr_reg + FIFO_IDX_W'(1);
        n_push      = FIFO_CNT_W'(push.rec_valid) + FIFO_CNT_W'(push.sum_valid);
        wr_next     = wr_reg + FIFO_IDX_W'(n_push);
        rd_next     = pop ? (rd_reg + FIFO_IDX_W'(1)) : rd_reg;
        cnt_next    = cnt_reg + n_push - FIFO_CNT_W'(pop);
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push.rec_valid || push.sum_valid) begin
            slot_reg[wr_reg] <= first_entry;
        end
        if (push.rec_valid && push.sum_valid) begin
            slot_reg[wr_second] <= push.sum;
        end
    end

    assign head      = slot_reg[rd_reg];
    assign not_empty = (cnt_reg != '0);
    assign count     = cnt_reg;

endmodule

`default_nettype wire

FILE: design/hid_report_descriptor_scanner_unit.sv
// HID report descriptor scanner: top level with the input register, the
// report limit register and the result port. Uses hrds_pkg, hrds_parser,
// hrds_result_fifo and the assertion macros header.
//
// Usage:
//   Descriptor bytes enter on the s_ stream, one per transfer; s_tlast marks
//   the last byte. Results leave on the m_ stream: m_tuser is the kind
//   (0 report record, 1 end-of-descriptor summary) and m_tlast marks the last
//   result caused by one byte. A byte causes no result, one, or two (a record
//   followed by the summary).
//   The report limit is written through cfg_we/cfg_wdata while the block is
//   idle (a rule for the user; the block itself does not enforce it); reset sets it to 4.
//   A byte waits in the input register until it is processed; its results are then
//   written into the result queue and shown on m_ from then on.
//   Throughput: one byte per cycle; the parse state update is a single
//   registered step per byte. A byte waits in the input register while the
//   four-entry result queue has fewer than two free places.
//   Reset clears the parse state, the input register and the result queue.
//   When the receiver stalls, results collect in the queue and input transfers
//   continue until it has fewer than two free places, after which s_tready falls.
`default_nettype none
`include "hid_report_descriptor_scanner_unit_defines.svh"

module hid_report_descriptor_scanner_unit (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // Configuration: report limit.
    input  wire logic                         cfg_we,
    input  wire logic [7:0]                   cfg_wdata,
    // Input stream.
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [7:0]                   s_tdata,   // [7:0] desc_byte
    input  wire logic                         s_tlast,   // final_byte
    // Result stream.
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // [7:0] report_ident, [23:8] page_of_usage, [31:24] usage_code,
    // [39:32] reports_found, [40] truncated, upper bits zero
    output logic [hrds_pkg::TDATA_W-1:0]      m_tdata,
    output logic                              m_tuser,   // kind
    output logic                              m_tlast    // run_end
);
    import hrds_pkg::*;

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_final_reg;
    logic [7:0]             max_reports_reg;
    logic                   room;
    logic                   step;
    logic                   pop;
    hrds_push_t             push;
    hrds_result_t           head;
    logic                   not_empty;
    logic [FIFO_CNT_W-1:0]  fifo_count;

    // Process the held byte only when the queue can take two results.
    assign room     = (fifo_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign step     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || room;
    assign pop      = m_tvalid && m_tready;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata;
            in_final_reg <= s_tlast;
        end
    end

    // Report limit register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reports_reg <= MAX_REPORTS_RST;
        end else if (cfg_we) begin
            max_reports_reg <= cfg_wdata;
        end
    end

    hrds_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .desc_byte   (in_byte_reg),
        .final_byte  (in_final_reg),
        .max_reports (max_reports_reg),
        .push        (push)
    );

    hrds_result_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .count     (fifo_count)
    );

    // Result port packing.
    assign m_tvalid = not_empty;
    assign m_tuser  = head.kind;
    assign m_tlast  = head.run_end;
    assign m_tdata  = {{(TDATA_W - RES_DATA_W){1'b0}}, head.truncated, head.reports_found,
                       head.usage_code, head.page_of_usage, head.report_ident};

    // Checks on the queue and the result stream.
    `HRDS_ASSERT(a_fifo_bound, aclk, aresetn, fifo_count <= FIFO_CNT_W'(FIFO_DEPTH))
    `HRDS_ASSERT_IMP(a_stall_held, aclk, aresetn, !s_tready, in_valid_reg)
    `HRDS_ASSERT_IMP(a_summary_last, aclk, aresetn, m_tvalid && m_tuser, m_tlast)
    `HRDS_ASSERT_IMP(a_record_count, aclk, aresetn, m_tvalid && !m_tuser, m_tdata[39:32] != 8'd0)

endmodule

`default_nettype wire
